/* hdl/matrix_vector_multiply_assert.svh */
// ----------------------------------------------------------------------------
// matrix_vector_multiply assertion macros
// concurrent check macros shared by the block, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS

// property holds in the same cycle
`define MVM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property holds in the next cycle
`define MVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MVM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define MVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/mvm_pkg.sv */
// ----------------------------------------------------------------------------
// mvm_pkg
// shared types and command codes of the matrix vector multiplier
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int IDX_W   = 4;
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;
    localparam int SIZE_W  = 5;
    localparam int FRAC_W  = 16;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 40;

    localparam logic [CMD_W-1:0] CMD_WR_MATRIX = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_VECTOR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MULTIPLY  = 2'd2;

    // write broadcast to every cell
    typedef struct packed {
        logic               mat_we;
        logic               vec_we;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] data;
    } wr_t;

    // row marker that travels with the partial sum
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
        logic             last;
    } tok_t;

endpackage

/* hdl/mvm_cell.sv */
// ----------------------------------------------------------------------------
// mvm_cell
// one column of the multiplier: holds its matrix column and vector element,
// adds its product to the partial sum passing through
// ----------------------------------------------------------------------------
module mvm_cell #(
    parameter int COL   = 0,
    parameter int DEPTH = 16,
    parameter int SW    = 32,
    parameter int ACC_W = 69
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic                    active,
    input  mvm_pkg::wr_t            wr,
    input  mvm_pkg::tok_t           tok_in,
    input  logic signed [ACC_W-1:0] sum_in,
    output mvm_pkg::tok_t           tok_out,
    output logic signed [ACC_W-1:0] sum_out
);
    import mvm_pkg::*;

    localparam int MIDX_W = $clog2(DEPTH);

    logic signed [SW-1:0]    col_mem [DEPTH];
    logic signed [SW-1:0]    x_reg;
    logic signed [SW-1:0]    a_reg;
    logic signed [2*SW-1:0]  prod_reg;
    logic signed [ACC_W-1:0] sum1_reg;
    logic signed [ACC_W-1:0] sum2_reg;
    logic signed [ACC_W-1:0] sum3_reg;
    tok_t                    tok1_reg;
    tok_t                    tok2_reg;
    tok_t                    tok3_reg;
    logic                    hit_col;
    logic                    row_ok;

    assign hit_col = (wr.col == IDX_W'(COL));
    assign row_ok  = ({1'b0, wr.row} < (IDX_W + 1)'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr.mat_we && hit_col && row_ok)
        begin
            col_mem[wr.row[MIDX_W-1:0]] <= wr.data[SW-1:0];
        end
        if (step)
        begin
            a_reg <= col_mem[tok_in.row[MIDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.vec_we && hit_col)
        begin
            x_reg <= wr.data[SW-1:0];
        end
        if (step)
        begin
            sum1_reg <= sum_in;
            sum2_reg <= sum1_reg;
            // columns beyond the size in use add nothing
            prod_reg <= active ? ((2*SW)'(a_reg) * (2*SW)'(x_reg)) : '0;
            sum3_reg <= sum2_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg <= '0;
            tok2_reg <= '0;
            tok3_reg <= '0;
        end
        else if (step)
        begin
            tok1_reg <= tok_in;
            tok2_reg <= tok1_reg;
            tok3_reg <= tok2_reg;
        end
    end

    assign tok_out = tok3_reg;
    assign sum_out = sum3_reg;

endmodule

/* hdl/matrix_vector_multiply.sv */
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// dense square matrix times vector, signed Q16.16, one cell per column
// ----------------------------------------------------------------------------
// Input words (s_*) carry a command in tuser: write a matrix entry, write a
// vector entry, or start a multiply. A write gives no result. A multiply
// sends rows 0..n-1 through a chain of min(MAX_SIZE,16) cells, one row per
// cycle while the chain is not stalled; each cell holds one matrix column
// and one vector element and adds its product to the partial sum, three
// register stages per cell (memory read, multiply, add). Results leave on
// m_* in row order, m_tlast on the final row, m_tuser set when the row sum
// was clipped. Each row passes the cell chain and then the output register.
// No input word is taken during a multiply.
// cfg_* writes matrix_size (always ready); write it only while idle.
// Reset sets matrix_size to 16; matrix and vector contents are undefined
// until written. A stall on m_tready freezes the whole chain, no words lost.
// ----------------------------------------------------------------------------
`include "matrix_vector_multiply_assert.svh"

module matrix_vector_multiply #(
    parameter int MAX_SIZE   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mvm_pkg::IN_W-1:0]    s_tdata,   // row_index[3:0], col_index[7:4], value[39:8]
    input  logic [mvm_pkg::CMD_W-1:0]   s_tuser,   // cmd[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mvm_pkg::OUT_W-1:0]   m_tdata,   // result_row[3:0], result_value[35:4], zero
    output logic                        m_tuser,   // saturated
    output logic                        m_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mvm_pkg::SIZE_W-1:0]  cfg_data
);
    import mvm_pkg::*;

    localparam int SW      = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int ROW_CAP = (MAX_SIZE < 16) ? MAX_SIZE : 16;
    localparam int NW      = $clog2(ROW_CAP + 1);
    localparam int ACC_W   = 2 * SW + $clog2(ROW_CAP) + 1;

    localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI - 1;
    localparam logic [VALUE_W-1:0]      OUT_HI = VALUE_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic [VALUE_W-1:0]      OUT_LO = ~OUT_HI;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                    state_reg;
    logic                    state_next;
    logic                    issuing_reg;
    logic                    issuing_next;
    logic [NW-1:0]           cnt_reg;
    logic [NW-1:0]           cnt_next;
    logic [SIZE_W-1:0]       size_reg;
    logic [NW-1:0]           used_n;
    logic                    issue_last;
    logic                    step;
    logic                    s_acc;
    wr_t                     wr;
    tok_t                    tok_chain [ROW_CAP+1];
    logic signed [ACC_W-1:0] sum_chain [ROW_CAP+1];
    logic signed [ACC_W-1:0] shifted;
    logic signed [SW-1:0]    clipped;
    logic                    clip;
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;
    logic                    m_tuser_reg;
    logic                    m_tlast_reg;

    assign s_acc     = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    // chain moves whenever the output register can take a word
    assign step      = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            used_n = NW'(1);
        end
        else if (size_reg > SIZE_W'(ROW_CAP))
        begin
            used_n = NW'(ROW_CAP);
        end
        else
        begin
            used_n = NW'(size_reg);
        end
    end

    assign wr.mat_we = s_acc && (s_tuser == CMD_WR_MATRIX);
    assign wr.vec_we = s_acc && (s_tuser == CMD_WR_VECTOR);
    assign wr.row    = s_tdata[3:0];
    assign wr.col    = s_tdata[7:4];
    assign wr.data   = s_tdata[39:8];

    assign issue_last = (NW'(cnt_reg + 1'b1) == used_n);

    always_comb
    begin
        state_next   = state_reg;
        issuing_next = issuing_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && (s_tuser == CMD_MULTIPLY))
                begin
                    state_next   = ST_RUN;
                    issuing_next = 1'b1;
                    cnt_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (step && issuing_reg)
                begin
                    cnt_next = NW'(cnt_reg + 1'b1);
                    if (issue_last)
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (m_tvalid_reg && m_tready && m_tlast_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next   = ST_IDLE;
                issuing_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            issuing_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            issuing_reg <= issuing_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign tok_chain[0].valid = issuing_reg;
    assign tok_chain[0].row   = IDX_W'(cnt_reg);
    assign tok_chain[0].last  = issue_last;
    assign sum_chain[0]       = '0;

    for (genvar j = 0; j < ROW_CAP; j++)
    begin : g_cell
        mvm_cell #(
            .COL   (j),
            .DEPTH (ROW_CAP),
            .SW    (SW),
            .ACC_W (ACC_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (step),
            .active  (NW'(j) < used_n),
            .wr      (wr),
            .tok_in  (tok_chain[j]),
            .sum_in  (sum_chain[j]),
            .tok_out (tok_chain[j+1]),
            .sum_out (sum_chain[j+1])
        );
    end

    // floor to Q16.16, then clip to the stored width
    assign shifted = sum_chain[ROW_CAP] >>> FRAC_W;

    always_comb
    begin
        clip    = 1'b0;
        clipped = shifted[SW-1:0];
        if (shifted > LIM_HI)
        begin
            clip    = 1'b1;
            clipped = LIM_HI[SW-1:0];
        end
        else if (shifted < LIM_LO)
        begin
            clip    = 1'b1;
            clipped = LIM_LO[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (step)
        begin
            m_tvalid_reg <= tok_chain[ROW_CAP].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && tok_chain[ROW_CAP].valid)
        begin
            m_tdata_reg <= {4'b0, VALUE_W'(clipped), tok_chain[ROW_CAP].row};
            m_tuser_reg <= clip;
            m_tlast_reg <= tok_chain[ROW_CAP].last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `MVM_ASSERT_NOW(a_idle_no_result, clk, rst_n, s_tready, !m_tvalid_reg, "result word while idle")
    `MVM_ASSERT_NOW(a_issue_in_run, clk, rst_n, issuing_reg, state_reg == ST_RUN, "row issued outside a multiply")
    `MVM_ASSERT_NEXT(a_start_run, clk, rst_n, s_acc && (s_tuser == CMD_MULTIPLY), issuing_reg && !s_tready, "multiply did not start")
    `MVM_ASSERT_NEXT(a_last_ends, clk, rst_n, m_tvalid && m_tready && m_tlast, s_tready, "block busy after last row")
    `MVM_ASSERT_NOW(a_sat_limit, clk, rst_n, m_tvalid && m_tuser, (m_tdata[35:4] == OUT_HI) || (m_tdata[35:4] == OUT_LO), "clipped word not at a limit")

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for matrix_vector_multiply: loads the matrix and the
// vector, starts multiplies at several sizes, and checks every row result
// against a bit-exact Q16.16 row-sum predictor, with random stalls on both
// streams
// ----------------------------------------------------------------------------
module tb;

    import mvm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int DIM           = 16;
    localparam int SETTLE_CYCLES = 64;      // wait after the last expected row is seen
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 48;

    typedef struct {
        logic [IDX_W-1:0]   result_row;
        logic [VALUE_W-1:0] result_value;
        logic               saturated;
        logic               last;
    } row_result_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata   = '0;
    logic [CMD_W-1:0]    s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SIZE_W-1:0]   cfg_data  = '0;

    // predictor state
    logic signed [VALUE_W-1:0] matrix_q [DIM][DIM];
    logic signed [VALUE_W-1:0] vector_q [DIM];
    logic [SIZE_W-1:0]         size_q = 5'd16;
    row_result_t               expected_rows [$];

    int  errors      = 0;
    int  cycle_count = 0;
    bit  no_idle     = 1'b0;

    matrix_vector_multiply #(
        .MAX_SIZE   (16),
        .DATA_WIDTH (32)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL matrix_vector_multiply");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 30);
    end

    // exact row sums, floored to Q16.16 and clipped to 32 bits
    function automatic void queue_row_sums();
        int                 n;
        logic signed [71:0] acc;
        logic signed [71:0] q;
        row_result_t        r;
        n = (size_q == 0) ? 1 : ((size_q > DIM) ? DIM : int'(size_q));
        for (int i = 0; i < n; i++)
        begin
            acc = '0;
            for (int j = 0; j < n; j++)
                acc = acc + matrix_q[i][j] * vector_q[j];
            q = acc >>> FRAC_W;
            r.saturated = 1'b0;
            if (q > 72'sd2147483647)
            begin
                q = 72'sd2147483647;
                r.saturated = 1'b1;
            end
            else if (q < -72'sd2147483648)
            begin
                q = -72'sd2147483648;
                r.saturated = 1'b1;
            end
            r.result_row   = IDX_W'(i);
            r.result_value = q[31:0];
            r.last         = (i == n - 1);
            expected_rows.push_back(r);
        end
    endfunction

    // mostly small values so sums stay in range, sometimes full 32-bit ones
    function automatic logic [VALUE_W-1:0] rand_value();
        logic [31:0] b;
        b = $urandom;
        if ($urandom_range(0, 3) == 0)
            return b;
        return {{14{b[17]}}, b[17:0]};
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VALUE_W-1:0] value);
        int idle_cycles;
        idle_cycles = 0;
        if (!no_idle)
            while ($urandom_range(0, 99) < 30)
                idle_cycles++;
        if (idle_cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (idle_cycles) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {value, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (cmd)
            CMD_WR_MATRIX: matrix_q[row][col] = value;
            CMD_WR_VECTOR: vector_q[col] = value;
            CMD_MULTIPLY:  queue_row_sums();
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] size);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        size_q = size;
    endtask

    task automatic multiply_random_fields();
        send_word(CMD_MULTIPLY, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    endtask

    // reset size is 16: load the whole store and multiply without a config write
    task automatic test_reset_size();
        for (int i = 0; i < DIM; i++)
            for (int j = 0; j < DIM; j++)
                send_word(CMD_WR_MATRIX, IDX_W'(i), IDX_W'(j), rand_value());
        for (int j = 0; j < DIM; j++)
            send_word(CMD_WR_VECTOR, IDX_W'($urandom), IDX_W'(j), rand_value());
        multiply_random_fields();
        wait_drained();
    endtask

    // negative product rounds towards minus infinity; unused command is dropped
    task automatic test_single_entry();
        write_size(5'd1);
        send_word(CMD_WR_MATRIX, 4'd0, 4'd0, 32'hFFFF_FFFF);
        send_word(CMD_WR_VECTOR, 4'hF, 4'd0, 32'h0000_0001);
        send_word(CMD_UNUSED, 4'hF, 4'hF, 32'hFFFF_FFFF);
        send_word(CMD_MULTIPLY, 4'd0, 4'd0, 32'd0);
        wait_drained();
    endtask

    task automatic test_saturation();
        write_size(5'd2);
        send_word(CMD_WR_MATRIX, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_word(CMD_WR_MATRIX, 4'd0, 4'd1, 32'h7FFF_FFFF);
        send_word(CMD_WR_MATRIX, 4'd1, 4'd0, 32'h8000_0000);
        send_word(CMD_WR_MATRIX, 4'd1, 4'd1, 32'h0001_0000);
        send_word(CMD_WR_VECTOR, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_word(CMD_WR_VECTOR, 4'd0, 4'd1, 32'h7FFF_FFFF);
        send_word(CMD_MULTIPLY, 4'hF, 4'hF, 32'hFFFF_FFFF);
        // max*(max+min) stays in range, min*max+min clips low
        send_word(CMD_WR_VECTOR, 4'd5, 4'd1, 32'h8000_0000);
        send_word(CMD_MULTIPLY, 4'd0, 4'd0, 32'd0);
        wait_drained();
    endtask

    // zero acts as one, anything above sixteen as sixteen
    task automatic test_size_limits();
        write_size(5'd0);
        multiply_random_fields();
        wait_drained();
        write_size(5'd31);
        multiply_random_fields();
        wait_drained();
        write_size(5'd17);
        multiply_random_fields();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int                words;
        int                phase;
        int                n;
        int                writes;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [SIZE_W-1:0] size;
        words = 0;
        phase = 0;
        while (words < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0:       size = 5'd16;
                1:       size = ($urandom_range(0, 1) == 0) ? 5'd0 : SIZE_W'($urandom_range(17, 31));
                default: size = SIZE_W'($urandom_range(1, 6));
            endcase
            write_size(size);
            n = (size == 0) ? 1 : ((size > DIM) ? DIM : int'(size));
            no_idle = (phase == 0);
            repeat (6)
            begin
                writes = $urandom_range(0, 2 * n);
                repeat (writes)
                begin
                    if ($urandom_range(0, 3) != 0)
                    begin
                        row = IDX_W'($urandom_range(0, n - 1));
                        col = IDX_W'($urandom_range(0, n - 1));
                    end
                    else
                    begin
                        row = IDX_W'($urandom);
                        col = IDX_W'($urandom);
                    end
                    case ($urandom_range(0, 7))
                        0:
                            send_word(CMD_UNUSED, row, col, $urandom);
                        1, 2, 3:
                        begin
                            send_word(CMD_WR_VECTOR, IDX_W'($urandom), col, rand_value());
                            words++;
                        end
                        default:
                        begin
                            send_word(CMD_WR_MATRIX, row, col, rand_value());
                            words++;
                        end
                    endcase
                end
                multiply_random_fields();
                words++;
            end
            wait_drained();
            phase++;
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        row_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_rows.size() == 0)
            begin
                $error("row result word with none expected: row %0d", m_tdata[3:0]);
                errors++;
            end
            else
            begin
                want = expected_rows.pop_front();
                if (m_tdata[3:0] !== want.result_row)
                begin
                    $error("result_row: expected %0d, got %0d", want.result_row, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[35:4] !== want.result_value)
                begin
                    $error("result_value: expected %h, got %h", want.result_value, m_tdata[35:4]);
                    errors++;
                end
                if (m_tuser !== want.saturated)
                begin
                    $error("saturated: expected %b, got %b", want.saturated, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_size();
        test_single_entry();
        test_saturation();
        test_size_limits();
        test_random_traffic();
        wait_drained();
        if (errors == 0)
            $display("PASS matrix_vector_multiply");
        else
            $display("FAIL matrix_vector_multiply");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/mvm_pkg.sv
hdl/mvm_cell.sv
hdl/matrix_vector_multiply.sv
test/tb.sv
